>>> hw/rtl/plil_pkg.sv
// Shared types, sizes and status codes for the positional list core.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
`timescale 1ns / 1ps

package plil_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [VAL_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  function automatic logic [VAL_W-1:0] to_port(input logic signed [DATA_WIDTH-1:0] v);
    return VAL_W'(v);
  endfunction

endpackage

>>> hw/rtl/positional_list_insert_delete_core.sv
// Channel  | Dir | tdata (low bit up)                        | tuser (low bit up)
// in_      | in  | position[4:0], value[36:5], zero pad to 40 | action[0], at_end[1]
// out_     | out | removed_value[31:0], entry_count[36:32]    | status[1:0]
//
// One item per cycle while each result is taken; its result is registered and shows in the cycle after the transfer.
// Every entry sits in its own cell; on insert or delete each entry at or after the position moves one place.
// Reset clears the entry count and the output valid only; entry contents stay undefined until written.
// A stalled result holds the input side until it is taken.
//
// Top level: instantiates plil_ctrl and a row of plil_cell; depends on plil_pkg.
`timescale 1ns / 1ps

module positional_list_insert_delete_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[4:0], value[36:5], zero pad
  input  logic [1:0]  in_tuser,   // action[0], at_end[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // removed_value[31:0], entry_count[36:32], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int DW = plil_pkg::DATA_WIDTH;
  localparam int CN = plil_pkg::CAPACITY;

  logic                           accept;
  logic                           action;
  logic                           at_end;
  logic [plil_pkg::POS_W-1:0]     position;
  logic signed [plil_pkg::VAL_W-1:0] in_value;
  plil_pkg::cmd_t                 cmd;
  plil_pkg::status_t              status;
  logic [plil_pkg::CNT_W-1:0]     count_nxt;
  logic [DW-1:0]                  new_value;
  logic [DW-1:0]                  cell_val [CN];
  logic [plil_pkg::VAL_W-1:0]     removed;

  logic                           out_tvalid_r;
  plil_pkg::status_t              status_r;
  logic [plil_pkg::VAL_W-1:0]     removed_r;
  logic [plil_pkg::CNT_W-1:0]     count_out_r;

  assign action    = in_tuser[0];
  assign at_end    = in_tuser[1];
  assign position  = in_tdata[4:0];
  assign in_value  = in_tdata[36:5];
  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign new_value = plil_pkg::to_store(in_value);

  plil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (action),
    .at_end    (at_end),
    .position  (position),
    .cmd       (cmd),
    .status    (status),
    .count_nxt (count_nxt)
  );

  for (genvar g = 0; g < CN; g++) begin : g_cell
    logic [DW-1:0] prev_v;
    logic [DW-1:0] next_v;
    if (g == 0) begin : g_first
      assign prev_v = new_value;
    end else begin : g_mid
      assign prev_v = cell_val[g-1];
    end
    if (g == CN - 1) begin : g_last
      assign next_v = cell_val[g];
    end else begin : g_inner
      assign next_v = cell_val[g+1];
    end
    plil_cell u_cell (
      .clk        (clk),
      .cell_idx   (plil_pkg::IDX_W'(g)),
      .cmd        (cmd),
      .new_value  (new_value),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_val[g])
    );
  end

  assign removed = (action && status == plil_pkg::ST_OK) ?
                   plil_pkg::to_port(cell_val[cmd.idx]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_tready) begin
      out_tvalid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status;
      removed_r   <= removed;
      count_out_r <= count_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, count_out_r, removed_r};

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> count_out_r <= plil_pkg::CNT_W'(CN))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status_r == plil_pkg::ST_FULL |-> count_out_r == plil_pkg::CNT_W'(CN))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status_r == plil_pkg::ST_EMPTY |-> count_out_r == '0 && removed_r == '0)
    else $error("empty status with entries or removed value");

  a_bad_removed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status_r == plil_pkg::ST_BAD_POS |-> removed_r == '0)
    else $error("bad position returned a value");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> out_tvalid && count_out_r == $past(u_ctrl.count_r) + 1'b1)
    else $error("insert did not advance the count");
`endif

endmodule

>>> hw/rtl/plil_ctrl.sv
// Item decode, range checks and entry count register for the positional list.
// Depends on plil_pkg.
`timescale 1ns / 1ps

module plil_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        action,
  input  logic                        at_end,
  input  logic [plil_pkg::POS_W-1:0]  position,
  output plil_pkg::cmd_t              cmd,
  output plil_pkg::status_t           status,
  output logic [plil_pkg::CNT_W-1:0]  count_nxt
);

  logic [plil_pkg::CNT_W-1:0] count_r;
  logic [plil_pkg::EXT_W-1:0] cnt_e;
  logic [plil_pkg::EXT_W-1:0] pos_e;
  logic [plil_pkg::EXT_W-1:0] pos_eff;
  logic                       do_ins;
  logic                       do_del;

  assign cnt_e = plil_pkg::EXT_W'(count_r);
  assign pos_e = plil_pkg::EXT_W'(position);

  always_comb begin
    status  = plil_pkg::ST_OK;
    pos_eff = '0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    if (!action) begin
      if (count_r >= plil_pkg::CNT_W'(plil_pkg::CAPACITY)) begin
        status = plil_pkg::ST_FULL;
      end else begin
        pos_eff = at_end ? cnt_e + 1'b1 : pos_e;
        if (pos_eff == '0 || pos_eff > cnt_e + 1'b1) begin
          status = plil_pkg::ST_BAD_POS;
        end else begin
          do_ins = 1'b1;
        end
      end
    end else begin
      if (count_r == '0) begin
        status = plil_pkg::ST_EMPTY;
      end else begin
        pos_eff = at_end ? cnt_e : pos_e;
        if (pos_eff == '0 || pos_eff > cnt_e) begin
          status = plil_pkg::ST_BAD_POS;
        end else begin
          do_del = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cmd.ins = accept & do_ins;
    cmd.del = accept & do_del;
    cmd.idx = plil_pkg::IDX_W'(pos_eff - 1'b1);
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_del) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/plil_cell.sv
// One list entry: holds its value, takes the new value or a neighbour's on insert, and a neighbour's on delete.
// Depends on plil_pkg.
`timescale 1ns / 1ps

module plil_cell (
  input  logic                             clk,
  input  logic [plil_pkg::IDX_W-1:0]       cell_idx,
  input  plil_pkg::cmd_t                   cmd,
  input  logic [plil_pkg::DATA_WIDTH-1:0]  new_value,
  input  logic [plil_pkg::DATA_WIDTH-1:0]  prev_value,
  input  logic [plil_pkg::DATA_WIDTH-1:0]  next_value,
  output logic [plil_pkg::DATA_WIDTH-1:0]  value
);

  logic [plil_pkg::DATA_WIDTH-1:0] value_r;
  logic [plil_pkg::DATA_WIDTH-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (cmd.ins) begin
      if (cell_idx == cmd.idx) begin
        value_nxt = new_value;
      end else if (cell_idx > cmd.idx) begin
        value_nxt = prev_value;
      end
    end else if (cmd.del && cell_idx >= cmd.idx) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule
